// ===== design/prd_pkg.sv =====
// shared constants and result word type for the pdu receive deframer
package prd_pkg;

   localparam int WORD_BYTES   = 8;
   localparam int LENGTH_BYTES = 4;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = WORD_BYTES * BYTE_W;
   localparam int LENGTH_W    = LENGTH_BYTES * BYTE_W;
   localparam int POS_W       = $clog2(WORD_BYTES);
   localparam int HDR_W       = $clog2(LENGTH_BYTES);
   localparam int SEG_SIZE_W  = 19;

   localparam logic [POS_W-1:0] POS_SUBSEG_COUNT = POS_W'(4);
   localparam logic [POS_W-1:0] POS_MSG_CODE     = POS_W'(6);
   localparam logic [POS_W-1:0] POS_LAST         = POS_W'(WORD_BYTES - 1);
   localparam logic [HDR_W-1:0] HDR_LAST         = HDR_W'(LENGTH_BYTES - 1);

   typedef struct packed {
      logic [WORD_W-1:0]     word;
      logic                  from_segment;
      logic                  last_of_pdu;
      logic [BYTE_W-1:0]     message_code;
      logic [BYTE_W-1:0]     segments_left;
      logic [SEG_SIZE_W-1:0] segment_size;
   } rsp_word_type;

endpackage

// ===== design/pdu_receive_deframer.sv =====
// top level of the pdu receive deframer: input register, core and result register
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_stall  | rx_byte, clear_all
//  rsp     | out       | rsp_valid/rsp_stall  | word, flags, message code, counts, size
//  csr     | in        | csr_write_enable     | logon code
//
// one byte a cycle while rsp is not stalled; an accepted byte waits in the input
// register until the core takes it, and its result word, if any, is on rsp the cycle after
// reset is synchronous and clears the deframer to await a control pdu length
// while rsp is stalled with a word held, one more byte is taken into the input
// register; further bytes are stalled until the held word is taken
module pdu_receive_deframer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [prd_pkg::BYTE_W-1:0]          req_rx_byte,
   input  logic                                req_clear_all,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [prd_pkg::WORD_W-1:0]          rsp_word,
   output logic                                rsp_from_segment,
   output logic                                rsp_last_of_pdu,
   output logic [prd_pkg::BYTE_W-1:0]          rsp_message_code,
   output logic [prd_pkg::BYTE_W-1:0]          rsp_segments_left,
   output logic [prd_pkg::SEG_SIZE_W-1:0]      rsp_segment_size,
   input  logic                                csr_write_enable,
   input  logic [prd_pkg::BYTE_W-1:0]          csr_write_data
);
   import prd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_clear_ff;
   logic              step;
   logic              res_valid;
   rsp_word_type      res_word;
   rsp_word_type      out_word;

   assign step        = in_valid_ff & (~rsp_valid | ~rsp_stall);
   assign req_stall   = in_valid_ff & ~step;
   assign in_valid_in = (req_valid & ~req_stall) | (in_valid_ff & ~step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_rx_byte;
         in_clear_ff <= req_clear_all;
      end
   end

   prd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .rx_byte          (in_byte_ff),
      .clear_all        (in_clear_ff),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .res_valid        (res_valid),
      .res_word         (res_word)
   );

   prd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step & res_valid),
      .load_word (res_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (out_word)
   );

   assign rsp_word          = out_word.word;
   assign rsp_from_segment  = out_word.from_segment;
   assign rsp_last_of_pdu   = out_word.last_of_pdu;
   assign rsp_message_code  = out_word.message_code;
   assign rsp_segments_left = out_word.segments_left;
   assign rsp_segment_size  = out_word.segment_size;

endmodule

// ===== design/prd_core.sv =====
// deframer state machine: length capture, word packing and header field capture
module prd_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [prd_pkg::BYTE_W-1:0]      rx_byte,
   input  logic                            clear_all,
   input  logic                            csr_write_enable,
   input  logic [prd_pkg::BYTE_W-1:0]      csr_write_data,
   output logic                            res_valid,
   output prd_pkg::rsp_word_type           res_word
);
   import prd_pkg::*;

   typedef enum logic [1:0] {
      PH_CTRL_LEN  = 2'd0,
      PH_CTRL_DATA = 2'd1,
      PH_SEG_LEN   = 2'd2,
      PH_SEG_DATA  = 2'd3
   } phase_type;

   phase_type             phase_ff,   phase_in;
   logic [HDR_W-1:0]      hdr_ff,     hdr_in;
   logic [LENGTH_W-1:0]   remain_ff,  remain_in;
   logic [WORD_W-1:0]     acc_ff,     acc_in;
   logic [POS_W-1:0]      pos_ff,     pos_in;
   logic                  first_ff,   first_in;
   logic [BYTE_W-1:0]     subcnt_ff,  subcnt_in;
   logic [BYTE_W-1:0]     msg_ff,     msg_in;
   logic [SEG_SIZE_W-1:0] segsize_ff, segsize_in;
   logic [BYTE_W-1:0]     logon_ff;
   logic [BYTE_W-1:0]     subcnt_dec;
   logic                  seg;
   logic                  last;

   assign subcnt_dec = subcnt_ff - BYTE_W'(1);
   assign seg        = (phase_ff == PH_SEG_DATA);

   always_comb begin
      phase_in   = phase_ff;
      hdr_in     = hdr_ff;
      remain_in  = remain_ff;
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      first_in   = first_ff;
      subcnt_in  = subcnt_ff;
      msg_in     = msg_ff;
      segsize_in = segsize_ff;
      res_valid  = 1'b0;
      last       = 1'b0;
      if (clear_all) begin
         phase_in   = PH_CTRL_LEN;
         hdr_in     = '0;
         remain_in  = '0;
         acc_in     = '0;
         pos_in     = '0;
         first_in   = 1'b1;
         subcnt_in  = '0;
         segsize_in = '0;
      end else if (phase_ff == PH_CTRL_LEN || phase_ff == PH_SEG_LEN) begin
         remain_in = {remain_ff[LENGTH_W-BYTE_W-1:0], rx_byte};
         if (hdr_ff != HDR_LAST) begin
            hdr_in = hdr_ff + HDR_W'(1);
         end else begin
            hdr_in   = '0;
            acc_in   = '0;
            pos_in   = '0;
            first_in = 1'b1;
            if (remain_in == '0) begin
               if (phase_ff == PH_SEG_LEN) begin
                  subcnt_in = subcnt_dec;
                  phase_in  = (subcnt_dec != '0) ? PH_SEG_LEN : PH_CTRL_LEN;
               end else begin
                  phase_in = PH_CTRL_LEN;
               end
            end else begin
               phase_in = (phase_ff == PH_SEG_LEN) ? PH_SEG_DATA : PH_CTRL_DATA;
            end
         end
      end else begin
         acc_in    = {acc_ff[WORD_W-BYTE_W-1:0], rx_byte};
         remain_in = (remain_ff != '0) ? remain_ff - LENGTH_W'(1) : remain_ff;
         if (first_ff) begin
            if (!seg) begin
               if (pos_ff == POS_SUBSEG_COUNT) begin
                  subcnt_in = rx_byte;
               end else if (pos_ff == POS_MSG_CODE) begin
                  msg_in = rx_byte;
               end
            end else if (pos_ff == POS_LAST && msg_ff == logon_ff) begin
               segsize_in = {acc_ff[BYTE_W-1:0], rx_byte, 3'b000};
            end
         end
         if (pos_ff != POS_LAST) begin
            pos_in = pos_ff + POS_W'(1);
         end else begin
            pos_in    = '0;
            first_in  = 1'b0;
            res_valid = 1'b1;
            last      = (remain_in == '0);
            if (last) begin
               if (seg) begin
                  subcnt_in = subcnt_dec;
                  phase_in  = (subcnt_dec != '0) ? PH_SEG_LEN : PH_CTRL_LEN;
               end else begin
                  phase_in = (subcnt_ff != '0) ? PH_SEG_LEN : PH_CTRL_LEN;
               end
               hdr_in   = '0;
               first_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      res_word.word          = acc_in;
      res_word.from_segment  = seg;
      res_word.last_of_pdu   = last;
      res_word.message_code  = msg_in;
      res_word.segments_left = subcnt_in;
      res_word.segment_size  = segsize_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CTRL_LEN;
         hdr_ff     <= '0;
         remain_ff  <= '0;
         acc_ff     <= '0;
         pos_ff     <= '0;
         first_ff   <= 1'b1;
         subcnt_ff  <= '0;
         msg_ff     <= '0;
         segsize_ff <= '0;
         logon_ff   <= '0;
      end else begin
         if (step) begin
            phase_ff   <= phase_in;
            hdr_ff     <= hdr_in;
            remain_ff  <= remain_in;
            acc_ff     <= acc_in;
            pos_ff     <= pos_in;
            first_ff   <= first_in;
            subcnt_ff  <= subcnt_in;
            msg_ff     <= msg_in;
            segsize_ff <= segsize_in;
         end
         if (csr_write_enable) begin
            logon_ff <= csr_write_data;
         end
      end
   end

endmodule

// ===== design/prd_out_reg.sv =====
// result word register with valid/stall handshake
module prd_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  prd_pkg::rsp_word_type load_word,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output prd_pkg::rsp_word_type rsp_word
);
   import prd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   assign valid_in  = load | (valid_ff & rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

endmodule

// ===== test/prd_word_checker.sv =====
// checker for the pdu receive deframer: predicts content words and compares them
module prd_word_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [prd_pkg::BYTE_W-1:0]      req_rx_byte,
   input  logic                            req_clear_all,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [prd_pkg::WORD_W-1:0]      rsp_word,
   input  logic                            rsp_from_segment,
   input  logic                            rsp_last_of_pdu,
   input  logic [prd_pkg::BYTE_W-1:0]      rsp_message_code,
   input  logic [prd_pkg::BYTE_W-1:0]      rsp_segments_left,
   input  logic [prd_pkg::SEG_SIZE_W-1:0]  rsp_segment_size,
   input  logic                            csr_write_enable,
   input  logic [prd_pkg::BYTE_W-1:0]      csr_write_data,
   output int                              error_count,
   output int                              pending_words,
   output int                              words_checked,
   output int                              segment_words
);
   import prd_pkg::*;

   typedef enum logic [1:0] {
      CTRL_LENGTH,
      CTRL_CONTENT,
      SEG_LENGTH,
      SEG_CONTENT
   } deframe_phase_type;

   logic [BYTE_W-1:0]     logon_code;
   deframe_phase_type     phase;
   logic [HDR_W-1:0]      header_seen;
   logic [LENGTH_W-1:0]   bytes_left;
   logic [WORD_W-1:0]     packed_word;
   logic [POS_W-1:0]      word_pos;
   logic                  first_word;
   logic [BYTE_W-1:0]     subseg_count;
   logic [BYTE_W-1:0]     message_code;
   logic [SEG_SIZE_W-1:0] segment_size;

   rsp_word_type expected_words[$];

   function automatic void clear_deframer();
      phase        = CTRL_LENGTH;
      header_seen  = '0;
      bytes_left   = '0;
      packed_word  = '0;
      word_pos     = '0;
      first_word   = 1'b1;
      subseg_count = '0;
      segment_size = '0;
   endfunction

   function automatic deframe_phase_type segment_done();
      subseg_count = subseg_count - 8'd1;
      return (subseg_count != 0) ? SEG_LENGTH : CTRL_LENGTH;
   endfunction

   function automatic void deframe_byte(input logic [BYTE_W-1:0] rx, input logic clear);
      logic            seg;
      logic            last;
      logic [POS_W-1:0] pos;
      logic [BYTE_W-1:0] left;
      rsp_word_type    w;
      if (clear) begin
         clear_deframer();
         return;
      end
      if (phase == CTRL_LENGTH || phase == SEG_LENGTH) begin
         bytes_left = {bytes_left[LENGTH_W-BYTE_W-1:0], rx};
         if (header_seen != HDR_LAST) begin
            header_seen = header_seen + HDR_W'(1);
            return;
         end
         header_seen = '0;
         packed_word = '0;
         word_pos    = '0;
         first_word  = 1'b1;
         if (bytes_left == 0)
            phase = (phase == SEG_LENGTH) ? segment_done() : CTRL_LENGTH;
         else
            phase = (phase == SEG_LENGTH) ? SEG_CONTENT : CTRL_CONTENT;
         return;
      end
      seg         = (phase == SEG_CONTENT);
      pos         = word_pos;
      packed_word = {packed_word[WORD_W-BYTE_W-1:0], rx};
      if (bytes_left != 0)
         bytes_left = bytes_left - LENGTH_W'(1);
      if (first_word) begin
         if (!seg) begin
            if (pos == POS_SUBSEG_COUNT)
               subseg_count = rx;
            else if (pos == POS_MSG_CODE)
               message_code = rx;
         end else if (pos == POS_LAST && message_code == logon_code) begin
            segment_size = {packed_word[15:8], rx, 3'b000};
         end
      end
      if (pos != POS_LAST) begin
         word_pos = pos + POS_W'(1);
         return;
      end
      word_pos   = '0;
      first_word = 1'b0;
      last       = (bytes_left == 0);
      left       = subseg_count;
      if (last) begin
         if (seg) begin
            phase = segment_done();
            left  = subseg_count;
         end else begin
            phase = (subseg_count != 0) ? SEG_LENGTH : CTRL_LENGTH;
         end
         header_seen = '0;
         first_word  = 1'b1;
      end
      w.word          = packed_word;
      w.from_segment  = seg;
      w.last_of_pdu   = last;
      w.message_code  = message_code;
      w.segments_left = left;
      w.segment_size  = segment_size;
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic void check_field(input string field, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         clear_deframer();
         message_code = '0;
         logon_code   = '0;
         expected_words.delete();
      end else begin
         if (csr_write_enable)
            logon_code = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word %0h with nothing pending", rsp_word);
               error_count++;
            end else begin
               w = expected_words.pop_front();
               check_field("word", w.word, rsp_word);
               check_field("from_segment", WORD_W'(w.from_segment),
                           WORD_W'(rsp_from_segment));
               check_field("last_of_pdu", WORD_W'(w.last_of_pdu),
                           WORD_W'(rsp_last_of_pdu));
               check_field("message_code", WORD_W'(w.message_code),
                           WORD_W'(rsp_message_code));
               check_field("segments_left", WORD_W'(w.segments_left),
                           WORD_W'(rsp_segments_left));
               check_field("segment_size", WORD_W'(w.segment_size),
                           WORD_W'(rsp_segment_size));
               words_checked++;
               if (w.from_segment)
                  segment_words++;
            end
         end
         if (req_valid && !req_stall)
            deframe_byte(req_rx_byte, req_clear_all);
      end
      pending_words = expected_words.size();
   end

endmodule

// ===== test/pdu_receive_deframer_tb.sv =====
// testbench top for the pdu receive deframer: link byte stimulus and verdict
module pdu_receive_deframer_tb;
   import prd_pkg::*;

   localparam int HOLD_AT_BYTE = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  req_clear_all = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [WORD_W-1:0]     rsp_word;
   logic                  rsp_from_segment;
   logic                  rsp_last_of_pdu;
   logic [BYTE_W-1:0]     rsp_message_code;
   logic [BYTE_W-1:0]     rsp_segments_left;
   logic [SEG_SIZE_W-1:0] rsp_segment_size;
   logic                  csr_write_enable = 1'b0;
   logic [BYTE_W-1:0]     csr_write_data = '0;

   int   error_count;
   int   pending_words;
   int   words_checked;
   int   segment_words;
   int   bytes_driven = 0;
   int   logon_writes = 0;
   bit   gaps_on = 1'b1;
   bit   long_hold_done = 1'b0;
   logic [BYTE_W-1:0] logon_now = '0;

   always #10 clock = ~clock;

   pdu_receive_deframer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_clear_all     (req_clear_all),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_word          (rsp_word),
      .rsp_from_segment  (rsp_from_segment),
      .rsp_last_of_pdu   (rsp_last_of_pdu),
      .rsp_message_code  (rsp_message_code),
      .rsp_segments_left (rsp_segments_left),
      .rsp_segment_size  (rsp_segment_size),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   prd_word_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_clear_all     (req_clear_all),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_word          (rsp_word),
      .rsp_from_segment  (rsp_from_segment),
      .rsp_last_of_pdu   (rsp_last_of_pdu),
      .rsp_message_code  (rsp_message_code),
      .rsp_segments_left (rsp_segments_left),
      .rsp_segment_size  (rsp_segment_size),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .error_count       (error_count),
      .pending_words     (pending_words),
      .words_checked     (words_checked),
      .segment_words     (segment_words)
   );

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom);
   endfunction

   task automatic push_byte(input logic [BYTE_W-1:0] value, input logic clear);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_rx_byte   <= value;
      req_clear_all <= clear;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_driven++;
   endtask

   task automatic send_length(input logic [LENGTH_W-1:0] len);
      for (int i = LENGTH_BYTES - 1; i >= 0; i--)
         push_byte(len[BYTE_W*i +: BYTE_W], 1'b0);
   endtask

   // content is padded to whole words; bytes 4, 6 and 7 of the first word are chosen
   task automatic send_pdu(input int len, input logic [BYTE_W-1:0] at4,
                           input logic [BYTE_W-1:0] at6, input logic [BYTE_W-1:0] at7);
      int padded;
      logic [BYTE_W-1:0] b;
      padded = ((len + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
      send_length(len);
      for (int i = 0; i < padded; i++) begin
         b = rand_byte();
         if (i == 4)
            b = at4;
         else if (i == 6)
            b = at6;
         else if (i == 7)
            b = at7;
         push_byte(b, 1'b0);
      end
   endtask

   task automatic send_message(input int ctrl_len, input logic [BYTE_W-1:0] count,
                               input logic [BYTE_W-1:0] code);
      send_pdu(ctrl_len, count, code, rand_byte());
      if (ctrl_len != 0)
         for (int i = 0; i < count; i++)
            send_pdu($urandom_range(0, 40), rand_byte(), rand_byte(), rand_byte());
   endtask

   task automatic wait_link_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_logon_code(input logic [BYTE_W-1:0] code);
      wait_link_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= code;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      logon_now = code;
      logon_writes++;
   endtask

   // receiver: random stall bursts, and one long hold once the run is under way
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!long_hold_done && bytes_driven >= HOLD_AT_BYTE) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #10000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int pick;
      int next_config_at;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_logon_code(8'h00);
      send_pdu(0, 8'h00, 8'h00, 8'h00);
      send_message(8, 8'h00, 8'hff);
      send_message(1, 8'h00, 8'h00);
      send_pdu(13, 8'd2, 8'h00, rand_byte());
      send_pdu(8, rand_byte(), 8'hff, 8'hff);
      send_pdu(0, rand_byte(), rand_byte(), rand_byte());
      send_pdu(16, 8'd1, 8'h5a, rand_byte());
      send_pdu(20, rand_byte(), 8'h12, 8'h34);
      // clear part way through a length
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b1);
      // huge length, abandoned by a clear
      send_length(32'hfedc_ba98);
      repeat (11) push_byte(rand_byte(), 1'b0);
      push_byte(8'h00, 1'b1);
      send_pdu(24, 8'd255, 8'h00, rand_byte());
      repeat (3) send_pdu($urandom_range(8, 16), rand_byte(), rand_byte(), rand_byte());
      push_byte(rand_byte(), 1'b1);
      // clear inside segment content
      send_pdu(8, 8'd1, 8'h00, rand_byte());
      send_length(16);
      repeat (5) push_byte(rand_byte(), 1'b0);
      push_byte(rand_byte(), 1'b1);
      write_logon_code(8'hff);
      send_pdu(8, 8'd2, 8'hff, rand_byte());
      send_pdu(9, rand_byte(), 8'h00, 8'h01);
      send_pdu(0, rand_byte(), 8'hff, 8'hff);

      next_config_at = bytes_driven + 300;
      while (bytes_driven < 1400) begin
         if (bytes_driven > 1100)
            gaps_on = 1'b0;
         if (bytes_driven >= next_config_at) begin
            next_config_at += 300;
            write_logon_code(BYTE_W'($urandom_range(0, 255)));
         end
         pick = $urandom_range(0, 19);
         if (pick < 17) begin
            send_message(($urandom_range(0, 19) == 0) ? $urandom_range(41, 120)
                                                      : $urandom_range(0, 40),
                         BYTE_W'($urandom_range(0, 3)),
                         $urandom_range(0, 1) ? logon_now : rand_byte());
         end else if (pick < 19) begin
            send_length($urandom_range(1, 40));
            repeat ($urandom_range(0, 12)) push_byte(rand_byte(), 1'b0);
            push_byte(rand_byte(), 1'b1);
         end else begin
            repeat ($urandom_range(1, 12)) push_byte(rand_byte(), 1'($urandom_range(0, 1)));
            push_byte(rand_byte(), 1'b1);
         end
      end

      wait_link_idle();
      repeat (8) @(negedge clock);
      $display("%0d link bytes driven across %0d logon code settings",
               bytes_driven, logon_writes);
      $display("%0d content words checked, %0d of them from segment pdus",
               words_checked, segment_words);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
design/prd_pkg.sv
design/prd_core.sv
design/prd_out_reg.sv
design/pdu_receive_deframer.sv
test/prd_word_checker.sv
test/pdu_receive_deframer_tb.sv
